### hdl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam logic [1:0] MODE_INS = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_LOC = 2'd2;
  localparam logic [1:0] MODE_RD  = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_POS  = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

### hdl/positional_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of up to CAPACITY elements held in a chain of shift cells.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream (mode in tuser, position and value in
// tdata); one result per request leaves on the out_ stream (status in tuser).
// Insert and any rejected request (bad position, full list, locate on an
// empty list) finish in the accept cycle: the result is valid the next cycle.
// Delete, read and locate rotate the occupied cells once through slot 0,
// one slot per cycle; delete then closes the gap in the same cycle the
// result is registered.
// One request is in work at a time. in_tready is high only when the engine
// is idle and the output register is empty or being drained, so a stalled
// receiver holds the result and blocks new requests without losing any.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; element contents are not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_core import ple_pkg::*; #(
  parameter int CAPACITY      = 128,
  parameter int ELEMENT_WIDTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // position[7:0], element_value[15:8]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // data_out[7:0], found_position[15:8],
                                  // list_length[23:16], is_empty[24], zero
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int EW = ELEMENT_WIDTH;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 9) ? CW : 9;
  localparam int DW = (EW > 8) ? EW : 8;
  localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);

  state_t        st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] hit_r, hit_nxt;
  logic [CW-1:0] sel_r, sel_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [EW-1:0] val_r, val_nxt;
  logic [EW-1:0] cap_r, cap_nxt;

  logic          ovalid_r, ovalid_nxt;
  logic [1:0]    ostat_r, ostat_nxt;
  logic [7:0]    odata_r, odata_nxt;
  logic [7:0]    ofound_r, ofound_nxt;
  logic [7:0]    olen_r, olen_nxt;
  logic          oempty_r, oempty_nxt;

  cell_op_t      cell_op;
  logic [CW-1:0] cell_sel;
  logic [CW-1:0] cell_top;
  logic [EW-1:0] cell_q [CAPACITY];
  logic [EW-1:0] head;

  logic          in_fire;
  logic          out_free;
  logic [7:0]    in_pos;
  logic [EW-1:0] in_val;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          ins_bad;
  logic          acc_bad;
  logic [CW-1:0] sel_in;
  logic [CW-1:0] cnt_dec;

  function automatic logic [7:0] to_byte(input logic [EW-1:0] v);
    logic [DW-1:0] w;
    w = DW'(v);
    return w[7:0];
  endfunction

  function automatic logic [7:0] cnt_byte(input logic [CW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return w[7:0];
  endfunction

  assign in_pos   = in_tdata[7:0];
  assign in_val   = EW'(in_tdata[15:8]);
  assign pos_x    = XW'(in_pos);
  assign cnt_x    = XW'(count_r);
  assign ins_bad  = (in_pos == 8'd0) || (pos_x > cnt_x + XW'(1));
  assign acc_bad  = (in_pos == 8'd0) || (pos_x > cnt_x);
  assign sel_in   = CW'(pos_x - XW'(1));
  assign cnt_dec  = count_r - CW'(1);
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign in_fire  = in_tvalid && in_tready;
  assign head     = cell_q[0];

  always_comb begin
    st_nxt     = st_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    hit_nxt    = hit_r;
    sel_nxt    = sel_r;
    mode_nxt   = mode_r;
    val_nxt    = val_r;
    cap_nxt    = cap_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ostat_nxt  = ostat_r;
    odata_nxt  = odata_r;
    ofound_nxt = ofound_r;
    olen_nxt   = olen_r;
    oempty_nxt = oempty_r;
    cell_op    = CELL_HOLD;
    cell_sel   = sel_r;
    cell_top   = cnt_dec;

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_tuser;
          sel_nxt    = sel_in;
          val_nxt    = in_val;
          k_nxt      = '0;
          hit_nxt    = '0;
          cap_nxt    = '0;
          ovalid_nxt = 1'b1;
          odata_nxt  = 8'd0;
          ofound_nxt = 8'd0;
          olen_nxt   = cnt_byte(count_r);
          oempty_nxt = (count_r == '0);
          case (in_tuser)
            MODE_INS: begin
              if (ins_bad) begin
                ostat_nxt = STAT_BAD_POS;
              end else if (count_r == CNT_MAX) begin
                ostat_nxt = STAT_FULL;
              end else begin
                ostat_nxt  = STAT_OK;
                cell_op    = CELL_INS;
                cell_sel   = sel_in;
                cell_top   = count_r;
                count_nxt  = count_r + CW'(1);
                olen_nxt   = cnt_byte(count_r + CW'(1));
                oempty_nxt = 1'b0;
              end
            end
            MODE_LOC: begin
              if (count_r == '0) begin
                ostat_nxt = STAT_NOTFOUND;
              end else begin
                ovalid_nxt = 1'b0;
                st_nxt     = ST_SCAN;
              end
            end
            default: begin
              if (acc_bad) begin
                ostat_nxt = STAT_BAD_POS;
              end else begin
                ovalid_nxt = 1'b0;
                st_nxt     = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        cell_op  = CELL_ROT;
        cell_top = cnt_dec;
        if (k_r == sel_r) begin
          cap_nxt = head;
        end
        if (hit_r == '0 && head == val_r) begin
          hit_nxt = k_r + CW'(1);
        end
        k_nxt = k_r + CW'(1);
        if (k_r == cnt_dec) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_nxt     = ST_IDLE;
          ovalid_nxt = 1'b1;
          ostat_nxt  = STAT_OK;
          odata_nxt  = 8'd0;
          ofound_nxt = 8'd0;
          olen_nxt   = cnt_byte(count_r);
          oempty_nxt = (count_r == '0);
          case (mode_r)
            MODE_DEL: begin
              cell_op    = CELL_DEL;
              cell_sel   = sel_r;
              cell_top   = cnt_dec;
              count_nxt  = cnt_dec;
              odata_nxt  = to_byte(cap_r);
              olen_nxt   = cnt_byte(cnt_dec);
              oempty_nxt = (cnt_dec == '0);
            end
            MODE_RD: begin
              odata_nxt = to_byte(cap_r);
            end
            MODE_LOC: begin
              if (hit_r == '0) begin
                ostat_nxt = STAT_NOTFOUND;
              end else begin
                ofound_nxt = cnt_byte(hit_r);
              end
            end
            default: ovalid_nxt = 1'b0;
          endcase
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EW-1:0] lower;
    logic [EW-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_q[g+1];
    end
    ple_cell #(
      .EW  (EW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .op_i    (cell_op),
      .sel_i   (cell_sel),
      .top_i   (cell_top),
      .ins_i   (val_nxt),
      .lower_i (lower),
      .upper_i (upper),
      .head_i  (head),
      .q_o     (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    hit_r    <= hit_nxt;
    sel_r    <= sel_nxt;
    mode_r   <= mode_nxt;
    val_r    <= val_nxt;
    cap_r    <= cap_nxt;
    ostat_r  <= ostat_nxt;
    odata_r  <= odata_nxt;
    ofound_r <= ofound_nxt;
    olen_r   <= olen_nxt;
    oempty_r <= oempty_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {7'd0, oempty_r, olen_r, ofound_r, odata_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count above capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (st_r == ST_IDLE))
    else $error("request accepted while busy");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (k_r < count_r))
    else $error("scan index past list end");

  a_fire_progress: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (ovalid_r || st_r == ST_SCAN))
    else $error("accepted request produced neither result nor scan");

endmodule

### hdl/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an element and takes it from a neighbor on a shift.
// ----------------------------------------------------------------------------
module ple_cell import ple_pkg::*; #(
  parameter int EW  = 8,
  parameter int CW  = 8,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_op_t      op_i,
  input  logic [CW-1:0] sel_i,    // target slot
  input  logic [CW-1:0] top_i,    // last slot taking part
  input  logic [EW-1:0] ins_i,
  input  logic [EW-1:0] lower_i,  // slot IDX-1
  input  logic [EW-1:0] upper_i,  // slot IDX+1
  input  logic [EW-1:0] head_i,   // slot 0
  output logic [EW-1:0] q_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [EW-1:0] elem_r;
  logic [EW-1:0] elem_nxt;

  always_comb begin
    elem_nxt = elem_r;
    case (op_i)
      CELL_INS: begin
        if (MY_IDX == sel_i) begin
          elem_nxt = ins_i;
        end else if (MY_IDX > sel_i && MY_IDX <= top_i) begin
          elem_nxt = lower_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= sel_i && MY_IDX < top_i) begin
          elem_nxt = upper_i;
        end
      end
      CELL_ROT: begin
        if (MY_IDX < top_i) begin
          elem_nxt = upper_i;
        end else if (MY_IDX == top_i) begin
          elem_nxt = head_i;
        end
      end
      default: elem_nxt = elem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign q_o = elem_r;

endmodule

### bench/positional_list_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb
// Self-checking bench for the positional list engine.
// ----------------------------------------------------------------------------
// A shadow list in the scoreboard predicts every response from the requests
// that were accepted. A short directed sequence covers empty-list rejects,
// inserts and deletes at the front, middle and end, reads and locates, hits,
// misses and duplicates. Random traffic then repeatedly fills the list to
// capacity, keeps inserting into the full list for a while, and drains it back
// to empty, with noise positions mixed in. Both handshake sides idle at random,
// with occasional back-to-back stretches.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
  import ple_pkg::*;

  localparam int CAPACITY    = 128;
  localparam int RAND_ITEMS  = 780;
  localparam int DRAIN_TAIL  = 140;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pos;
    logic [7:0] value;
  } list_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data;
    logic [7:0] found;
    logic [7:0] length;
    logic       empty;
  } list_rsp_t;

  class list_scoreboard;
    logic [7:0] shadow_elems [CAPACITY];
    int         shadow_len;
    list_rsp_t  pending_results [$];
    int         mismatches;
    int         checked;
    int         peak_len;
    int         status_seen [4];

    function void note_request(list_req_t req);
      list_rsp_t rsp;
      int        p;
      int        j;
      rsp = '0;
      rsp.status = STAT_OK;
      p = int'(req.pos);
      case (req.mode)
        MODE_INS: begin
          if (p < 1 || p > shadow_len + 1) begin
            rsp.status = STAT_BAD_POS;
          end else if (shadow_len >= CAPACITY) begin
            rsp.status = STAT_FULL;
          end else begin
            for (j = shadow_len; j >= p; j--) shadow_elems[j] = shadow_elems[j-1];
            shadow_elems[p-1] = req.value;
            shadow_len++;
          end
        end
        MODE_DEL: begin
          if (p < 1 || p > shadow_len) begin
            rsp.status = STAT_BAD_POS;
          end else begin
            rsp.data = shadow_elems[p-1];
            for (j = p; j < shadow_len; j++) shadow_elems[j-1] = shadow_elems[j];
            shadow_len--;
          end
        end
        MODE_LOC: begin
          rsp.status = STAT_NOTFOUND;
          for (j = 0; j < shadow_len; j++) begin
            if (shadow_elems[j] == req.value) begin
              rsp.status = STAT_OK;
              rsp.found  = 8'(j + 1);
              break;
            end
          end
        end
        default: begin
          if (p < 1 || p > shadow_len) rsp.status = STAT_BAD_POS;
          else rsp.data = shadow_elems[p-1];
        end
      endcase
      rsp.length = 8'(shadow_len);
      rsp.empty  = (shadow_len == 0);
      if (shadow_len > peak_len) peak_len = shadow_len;
      pending_results.push_back(rsp);
    endfunction

    function void check_result(list_rsp_t act);
      list_rsp_t exp;
      checked++;
      status_seen[act.status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] response with nothing pending: %s st=%0d data=%02h found=%0d",
                   $realtime, "", act.status, act.data, act.found,
                   " len=%0d empty=%0b", act.length, act.empty);
        return;
      end
      exp = pending_results.pop_front();
      if (act.status !== exp.status || act.data !== exp.data || act.found !== exp.found ||
          act.length !== exp.length || act.empty !== exp.empty) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] bad response: exp st=%0d data=%02h found=%0d len=%0d empty=%0b",
                   $realtime, exp.status, exp.data, exp.found, exp.length, exp.empty);
          $display("    got st=%0d data=%02h found=%0d len=%0d empty=%0b",
                   act.status, act.data, act.found, act.length, act.empty);
        end
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = MODE_INS;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  list_scoreboard sb = new();

  bit growing    = 1'b1;
  int full_dwell = 25;
  bit tx_burst   = 1'b0;
  bit rx_burst   = 1'b0;
  int rx_hold    = 0;
  int items_sent = 0;

  always #6 clk = ~clk;

  positional_list_engine_core #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (8)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic list_req_t pack_req(logic [1:0] mode, logic [7:0] pos, logic [7:0] value);
    list_req_t req;
    req.mode  = mode;
    req.pos   = pos;
    req.value = value;
    return req;
  endfunction

  // grow to full, linger on full, then drain to empty; repeat
  function list_req_t make_request();
    list_req_t req;
    int        len;
    int        pick;
    len = sb.shadow_len;
    if (growing && len == CAPACITY) begin
      if (full_dwell == 0) growing = 1'b0;
      else full_dwell--;
    end else if (!growing && len == 0) begin
      growing    = 1'b1;
      full_dwell = 25;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70)      req.mode = growing ? MODE_INS : MODE_DEL;
    else if (pick < 80) req.mode = growing ? MODE_DEL : MODE_INS;
    else if (pick < 90) req.mode = MODE_LOC;
    else                req.mode = MODE_RD;
    req.value = 8'($urandom_range(0, 255));
    case (req.mode)
      MODE_INS: req.pos = 8'($urandom_range(1, len + 1));
      MODE_LOC: begin
        req.pos = 8'($urandom_range(0, 255));
        if (len > 0 && $urandom_range(0, 9) < 6)
          req.value = sb.shadow_elems[$urandom_range(0, len - 1)];
      end
      default:  req.pos = (len == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, len));
    endcase
    if ($urandom_range(0, 9) == 0) req.pos = 8'($urandom_range(0, 255));
    return req;
  endfunction

  task send_request(input list_req_t req);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.mode;
    in_tdata  <= {req.value, req.pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req);
    items_sent++;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_result({out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                         out_tdata[24]});
        rx_hold = rx_burst ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_tready <= (rx_hold == 0);
    end
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-list rejects
    send_request(pack_req(MODE_LOC, 8'd0,   8'h00));
    send_request(pack_req(MODE_DEL, 8'd1,   8'h00));
    send_request(pack_req(MODE_RD,  8'd1,   8'hFF));
    send_request(pack_req(MODE_INS, 8'd0,   8'h11));
    send_request(pack_req(MODE_INS, 8'd2,   8'h22));
    // build 0xA5 0x00 0x5A 0xFF
    send_request(pack_req(MODE_INS, 8'd1,   8'h00));
    send_request(pack_req(MODE_INS, 8'd2,   8'hFF));
    send_request(pack_req(MODE_INS, 8'd1,   8'hA5));
    send_request(pack_req(MODE_INS, 8'd3,   8'h5A));
    send_request(pack_req(MODE_INS, 8'd6,   8'h33));
    send_request(pack_req(MODE_INS, 8'd255, 8'hFF));
    send_request(pack_req(MODE_RD,  8'd1,   8'h00));
    send_request(pack_req(MODE_RD,  8'd4,   8'hFF));
    send_request(pack_req(MODE_RD,  8'd5,   8'h00));
    send_request(pack_req(MODE_RD,  8'd0,   8'h00));
    send_request(pack_req(MODE_LOC, 8'd255, 8'hFF));
    send_request(pack_req(MODE_LOC, 8'd3,   8'h77));
    // duplicate at the tail, locate must report the first one
    send_request(pack_req(MODE_INS, 8'd5,   8'hA5));
    send_request(pack_req(MODE_LOC, 8'd0,   8'hA5));
    send_request(pack_req(MODE_DEL, 8'd0,   8'hFF));
    send_request(pack_req(MODE_DEL, 8'd6,   8'h00));
    send_request(pack_req(MODE_DEL, 8'd2,   8'hFF));
    send_request(pack_req(MODE_DEL, 8'd4,   8'h00));
    send_request(pack_req(MODE_DEL, 8'd1,   8'h00));

    repeat (RAND_ITEMS) send_request(make_request());
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("%0d requests sent, %0d responses checked, peak list length %0d",
             items_sent, sb.checked, sb.peak_len);
    $display("status mix ok/bad-pos/full/not-found: %0d/%0d/%0d/%0d, mismatches %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_BAD_POS],
             sb.status_seen[STAT_FULL], sb.status_seen[STAT_NOTFOUND], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_core.sv
bench/positional_list_engine_core_tb.sv
